FILE: src/hstc_pkg.sv
// ----------------------------------------------------------------------------
// hstc_pkg: shared types and constants for the help text space compressor
// Character codes, coding offsets and the result bundle that passes from the
// classifier to the byte serialiser.
// ----------------------------------------------------------------------------
package hstc_pkg;

  localparam int CHAR_W      = 7;
  localparam int BYTE_W      = 8;
  localparam int MAX_BYTES   = 3;
  localparam int NBYTES_W    = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CHR_END   = 7'h00;
  localparam logic [CHAR_W-1:0] CHR_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] ONE_SPACE_MIN  = 7'h40;
  localparam logic [CHAR_W-1:0] TWO_SPACE_BASE = 7'h60;

  localparam logic [BYTE_W-1:0] ONE_SPACE_OFS = 8'h40;
  localparam logic [BYTE_W-1:0] TWO_SPACE_OFS = 8'h60;
  localparam logic [BYTE_W-1:0] LF_BYTE       = 8'h0a;
  localparam logic [BYTE_W-1:0] LF_SUBST      = 8'h7f;
  localparam logic [BYTE_W-1:0] RUN_BASE      = 8'hc0;
  localparam logic [BYTE_W-1:0] RUN_MAX_BYTE  = 8'hff;
  localparam logic [BYTE_W-1:0] SPACE_BYTE    = 8'h20;
  localparam logic [BYTE_W-1:0] TERM_BYTE     = 8'h00;

  localparam logic [CHAR_W-1:0] RUN_MAX     = 7'd65;
  localparam logic [CHAR_W-1:0] HELD_SPACES = 7'd3;

  // Up to three coded bytes produced by one input character.
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [NBYTES_W-1:0]              count;
    logic                             term;
  } hstc_bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } hstc_qstat_t;

endpackage

FILE: src/hstc_front.sv
// ----------------------------------------------------------------------------
// hstc_front: character classifier
// Holds the pending character and its space count, and turns each accepted
// character into a bundle of zero to three coded bytes.
// ----------------------------------------------------------------------------
module hstc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hstc_pkg::CHAR_W-1:0]         in_char,
  input  hstc_pkg::hstc_qstat_t               qstat,
  output logic                                push,
  output hstc_pkg::hstc_bundle_t              bundle
);

  logic [hstc_pkg::CHAR_W-1:0] held_char, held_char_next;
  logic                        held_valid, held_valid_next;
  logic [hstc_pkg::CHAR_W-1:0] space_count, space_count_next;
  logic                        accept;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [hstc_pkg::NBYTES_W-1:0] n;
    logic [hstc_pkg::CHAR_W-1:0]   cnt;
    logic [hstc_pkg::BYTE_W-1:0]   cb;
    logic [hstc_pkg::BYTE_W-1:0]   v;
    n   = '0;
    cnt = space_count;
    cb  = {1'b0, held_char};
    v   = '0;
    bundle.bytes = '0;
    bundle.term  = 1'b0;
    held_char_next   = held_char;
    held_valid_next  = held_valid;
    space_count_next = space_count;

    if (in_char == hstc_pkg::CHR_SPACE) begin
      cnt = space_count + 7'd1;
      space_count_next = cnt;
      if (held_valid && cnt >= hstc_pkg::HELD_SPACES) begin
        // Too many spaces to fold into the character: send it plain.
        bundle.bytes[n] = cb;
        n = n + 2'd1;
        held_valid_next = 1'b0;
        held_char_next  = '0;
      end
      if (!held_valid && cnt >= hstc_pkg::RUN_MAX) begin
        bundle.bytes[n] = hstc_pkg::RUN_MAX_BYTE;
        n = n + 2'd1;
        space_count_next = '0;
      end
    end else begin
      // Resolve the held character and the spaces after it.
      if (held_valid) begin
        if (cnt == 7'd1 && held_char >= hstc_pkg::ONE_SPACE_MIN) begin
          bundle.bytes[n] = cb + hstc_pkg::ONE_SPACE_OFS;
          cnt = '0;
        end else if (cnt == 7'd2 && held_char > hstc_pkg::TWO_SPACE_BASE) begin
          v = cb - hstc_pkg::TWO_SPACE_OFS;
          bundle.bytes[n] = (v == hstc_pkg::LF_BYTE) ? hstc_pkg::LF_SUBST : v;
          cnt = '0;
        end else begin
          bundle.bytes[n] = cb;
        end
        n = n + 2'd1;
      end
      if (cnt >= 7'd2) begin
        bundle.bytes[n] = hstc_pkg::RUN_BASE + {1'b0, cnt} - 8'd2;
        n = n + 2'd1;
      end else if (cnt == 7'd1) begin
        bundle.bytes[n] = hstc_pkg::SPACE_BYTE;
        n = n + 2'd1;
      end
      space_count_next = '0;
      if (in_char == hstc_pkg::CHR_END) begin
        bundle.bytes[n] = hstc_pkg::TERM_BYTE;
        n = n + 2'd1;
        bundle.term = 1'b1;
        held_valid_next = 1'b0;
        held_char_next  = '0;
      end else begin
        held_valid_next = 1'b1;
        held_char_next  = in_char;
      end
    end
    bundle.count = n;
  end

  assign push = accept && (bundle.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_char   <= '0;
      held_valid  <= 1'b0;
      space_count <= '0;
    end else if (accept) begin
      held_char   <= held_char_next;
      held_valid  <= held_valid_next;
      space_count <= space_count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    space_count <= hstc_pkg::RUN_MAX)
    else $error("space count beyond the longest run");

  a_held_spaces: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> space_count < hstc_pkg::HELD_SPACES)
    else $error("held character with too many spaces");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_char == hstc_pkg::CHR_END |=> !held_valid && space_count == '0)
    else $error("state not cleared at end of string");

endmodule

FILE: src/hstc_queue.sv
// ----------------------------------------------------------------------------
// hstc_queue: bundle queue
// Short first-in first-out store of result bundles between classifier and
// serialiser.
// ----------------------------------------------------------------------------
module hstc_queue #(
  parameter int DEPTH = hstc_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  hstc_pkg::hstc_bundle_t wr_bundle,
  input  logic                   pop,
  output hstc_pkg::hstc_bundle_t rd_bundle,
  output hstc_pkg::hstc_qstat_t  qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  hstc_pkg::hstc_bundle_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == FULL_CNT);
  assign rd_bundle   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty))
    else $error("pop from an empty queue");

endmodule

FILE: src/hstc_back.sv
// ----------------------------------------------------------------------------
// hstc_back: byte serialiser
// Sends the bytes of the bundle at the head of the queue one per cycle while
// out_ready is high and releases the bundle with its last byte.
// ----------------------------------------------------------------------------
module hstc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  hstc_pkg::hstc_bundle_t        head,
  input  hstc_pkg::hstc_qstat_t         qstat,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hstc_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last
);

  logic [hstc_pkg::NBYTES_W-1:0] idx;
  logic                          final_byte;

  assign out_valid  = !qstat.empty;
  assign final_byte = (idx == head.count - 2'd1);
  assign out_byte   = head.bytes[idx];
  assign out_last   = head.term && final_byte;
  assign pop        = out_valid && out_ready && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_valid && out_ready) begin
      idx <= final_byte ? '0 : idx + 2'd1;
    end
  end

endmodule

FILE: src/help_text_space_compressor_top.sv
// ----------------------------------------------------------------------------
// help_text_space_compressor_top: space compressor for 7-bit help text
// Classifier, bundle queue and byte serialiser joined to stream ports.
// ----------------------------------------------------------------------------
// The block takes one 7-bit character per request on the slave side and
// sends compressed bytes on the master side; character 0 ends a string, and
// its terminator byte 0 goes out with tlast high, after which all state is
// clear for the next string. A character is taken in the cycle it arrives
// whenever the bundle queue (QUEUE_DEPTH entries) has room, so requests can
// follow back to back. Each character yields zero to three bytes, which the
// serialiser sends at one byte per cycle while m_tready is high; the sustained
// rate is therefore set by the output side, which for ordinary text (mostly
// one byte per character) is about one character per cycle.
// The first byte of a request's bundle is offered in the cycle right after it
// is taken if the queue was empty: the classifier works combinationally and
// writes its bundle into the queue register at the accepting edge.
// ----------------------------------------------------------------------------
module help_text_space_compressor_top #(
  parameter int QUEUE_DEPTH = hstc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [6:0] in_char, [7] zero fill
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // out_last
);

  hstc_pkg::hstc_bundle_t wr_bundle;
  hstc_pkg::hstc_bundle_t head;
  hstc_pkg::hstc_qstat_t  qstat;
  logic                   push;
  logic                   pop;

  // Front: classify each character against the held one and its spaces.
  hstc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_char  (s_tdata[hstc_pkg::CHAR_W-1:0]),
    .qstat    (qstat),
    .push     (push),
    .bundle   (wr_bundle)
  );

  // The queue lets the classifier run on while the serialiser is stalled.
  hstc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_bundle (wr_bundle),
    .pop       (pop),
    .rd_bundle (head),
    .qstat     (qstat)
  );

  // Back: one coded byte per cycle to the master side while m_tready is high.
  hstc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

  // The end of a string is always marked on the terminator byte itself.
  a_last_is_term: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == hstc_pkg::TERM_BYTE)
    else $error("tlast on a byte other than the terminator");

endmodule

FILE: tb/sv/tb_help_text_space_compressor_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_help_text_space_compressor_top: self-checking bench for the compressor
// Feeds directed and random text strings through the slave stream, predicts
// the coded byte stream in a scoreboard and checks every byte that leaves
// the master stream, under random input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module tb_help_text_space_compressor_top;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_CHARS  = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_OFF_LEN  = 300;
  localparam int HOLD_OFF_AT   = 120;
  localparam int DRAIN_CYCLES  = 16;
  localparam int REPORT_MAX    = 10;
  localparam int DIRECTED_LEN  = 33;

  // One coded byte as it should leave the block.
  typedef struct packed {
    logic [hstc_pkg::BYTE_W-1:0] code;
    logic                        last;
  } coded_byte_t;

  // Scoreboard: keeps its own copy of the compressor state, turns each
  // accepted character into the bytes it must cause, and checks the bytes
  // that come out against them in order.
  class space_code_checker;
    coded_byte_t                 pending_bytes[$];
    logic [hstc_pkg::CHAR_W-1:0] held_char  = '0;
    logic                        held_ok    = 1'b0;
    logic [hstc_pkg::CHAR_W-1:0] run_len    = '0;
    int                chars_in     = 0;
    int                bytes_out    = 0;
    int                faults       = 0;
    int                strings_done = 0;
    int                full_runs    = 0;
    int                paired_codes = 0;

    function void push_code(logic [hstc_pkg::BYTE_W-1:0] code, logic last);
      coded_byte_t item;
      item.code = code;
      item.last = last;
      pending_bytes.push_back(item);
    endfunction

    function void clear_state();
      held_char = '0;
      held_ok   = 1'b0;
      run_len   = '0;
    endfunction

    // A non-space or the end of the string follows: settle the held
    // character together with the spaces counted after it.
    function void resolve_held();
      logic [hstc_pkg::CHAR_W-1:0] cnt;
      logic [hstc_pkg::BYTE_W-1:0] v;
      cnt = run_len;
      if (held_ok) begin
        if (cnt == 7'd1 && held_char >= hstc_pkg::ONE_SPACE_MIN) begin
          push_code({1'b0, held_char} + hstc_pkg::ONE_SPACE_OFS, 1'b0);
          paired_codes++;
          cnt = '0;
        end else if (cnt == 7'd2 && held_char > hstc_pkg::TWO_SPACE_BASE) begin
          v = {1'b0, held_char} - hstc_pkg::TWO_SPACE_OFS;
          if (v == hstc_pkg::LF_BYTE) v = hstc_pkg::LF_SUBST;
          push_code(v, 1'b0);
          paired_codes++;
          cnt = '0;
        end else begin
          push_code({1'b0, held_char}, 1'b0);
        end
      end
      if (cnt >= 7'd2)
        push_code(hstc_pkg::RUN_BASE + {1'b0, cnt} - 8'd2, 1'b0);
      else if (cnt == 7'd1)
        push_code(hstc_pkg::SPACE_BYTE, 1'b0);
      clear_state();
    endfunction

    function void note_char(logic [hstc_pkg::CHAR_W-1:0] c);
      chars_in++;
      if (c == hstc_pkg::CHR_END) begin
        resolve_held();
        push_code(hstc_pkg::TERM_BYTE, 1'b1);
        strings_done++;
      end else if (c == hstc_pkg::CHR_SPACE) begin
        run_len = run_len + 7'd1;
        // A third space means the held character can no longer absorb them.
        if (held_ok && run_len >= hstc_pkg::HELD_SPACES) begin
          push_code({1'b0, held_char}, 1'b0);
          held_ok   = 1'b0;
          held_char = '0;
        end
        if (!held_ok && run_len >= hstc_pkg::RUN_MAX) begin
          push_code(hstc_pkg::RUN_MAX_BYTE, 1'b0);
          full_runs++;
          run_len = '0;
        end
      end else begin
        resolve_held();
        held_char = c;
        held_ok   = 1'b1;
      end
    endfunction

    function void check_byte(logic [hstc_pkg::BYTE_W-1:0] code, logic last);
      coded_byte_t want;
      bytes_out++;
      if (pending_bytes.size() == 0) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("[%0t] unexpected byte %02h last %0b", $time, code, last);
        return;
      end
      want = pending_bytes.pop_front();
      if (want.code !== code || want.last !== last) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("[%0t] byte %0d: expected %02h last %0b, got %02h last %0b",
                   $time, bytes_out, want.code, want.last, code, last);
      end
    endfunction
  endclass

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  space_code_checker sb;
  int  burst_left = 0;
  int  idle_cycles = 0;
  bit  held_off = 1'b0;

  help_text_space_compressor_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Offers one character and waits for the block to take it. The sender
  // works in bursts; between bursts it mostly lowers tvalid for a random gap.
  task automatic send_char(input logic [hstc_pkg::CHAR_W-1:0] c);
    int gap;
    s_tdata  <= {1'b0, c};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_char(c);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_spaces(input int n);
    repeat (n) send_char(hstc_pkg::CHR_SPACE);
  endtask

  // Mostly characters that can take part in a space code, but the full
  // 7-bit range comes up too. Space and the terminator are placed apart.
  function automatic logic [hstc_pkg::CHAR_W-1:0] pick_char();
    logic [hstc_pkg::CHAR_W-1:0] c;
    logic [31:0]                 r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        r = $urandom_range(8'h40, 8'h7f);
        c = r[hstc_pkg::CHAR_W-1:0];
      end
      5: begin
        c = hstc_pkg::TWO_SPACE_BASE + 7'h0a;
      end
      default: begin
        r = $urandom_range(1, 8'h7f);
        c = r[hstc_pkg::CHAR_W-1:0];
      end
    endcase
    if (c == hstc_pkg::CHR_SPACE) c = hstc_pkg::CHR_SPACE + 7'd1;
    return c;
  endfunction

  // Length of the space run after a character. Long runs that need
  // splitting are rare and kept to a few, since each costs many requests.
  function automatic int pick_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 65) return 1;
    if (r < 85) return 2;
    if (r < 96 || sb.full_runs >= 3) return $urandom_range(3, 6);
    return $urandom_range(60, 140);
  endfunction

  // Every byte leaving the master side is checked at the edge it is taken.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_byte(m_tdata, m_tlast);
  end

  // Watchdog: the run ends if neither side moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("no request accepted for %0d cycles", STALL_LIMIT);
        $display("help_text_space_compressor_top verification failed");
        $finish;
      end
    end
  end

  // Receiver: stretches of steady readiness, random stalls and a sparse
  // pattern, plus one long hold-off while the sender keeps offering, so
  // that the queue fills and the block stalls its slave side.
  initial begin
    int mode;
    int len;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && sb.chars_in >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(20, 60);
        for (int i = 0; i < len; i++) begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= (i % 4 == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Stimulus: the directed strings first, then random well-formed strings.
  initial begin
    logic [hstc_pkg::CHAR_W-1:0] directed [DIRECTED_LEN];
    int start;
    int tokens;
    sb = new;
    // Empty string; one-space and two-space codes including the line feed
    // substitution; characters just below each coding range; a held
    // character released by a third space; a lone space at the start.
    directed = '{7'h00,
                 7'h40, 7'h20, 7'h00,
                 7'h3f, 7'h20, 7'h41, 7'h00,
                 7'h6a, 7'h20, 7'h20, 7'h00,
                 7'h61, 7'h20, 7'h20, 7'h7f, 7'h20, 7'h20, 7'h00,
                 7'h60, 7'h20, 7'h20, 7'h00,
                 7'h7f, 7'h20, 7'h20, 7'h20, 7'h01, 7'h00,
                 7'h20, 7'h41, 7'h7f, 7'h20};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_char(directed[i]);
    send_char(hstc_pkg::CHR_END);
    start = sb.chars_in;

    while (sb.chars_in - start < RANDOM_CHARS) begin
      if ($urandom_range(0, 9) == 0) send_spaces($urandom_range(1, 4));
      tokens = $urandom_range(0, 12);
      for (int t = 0; t < tokens; t++) begin
        send_char(pick_char());
        send_spaces(pick_run());
      end
      send_char(hstc_pkg::CHR_END);
    end
    s_tvalid <= 1'b0;

    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d strings, %0d characters in, %0d bytes checked, %0d faults",
             sb.strings_done, sb.chars_in, sb.bytes_out, sb.faults);
    $display("%0d character-and-space codes, %0d maximal space runs split",
             sb.paired_codes, sb.full_runs);
    if (sb.faults == 0 && sb.pending_bytes.size() == 0) begin
      $display("help_text_space_compressor_top verification clean");
    end else begin
      $display("help_text_space_compressor_top verification failed");
    end
    $finish;
  end

endmodule

FILE: help_text_space_compressor_top.f
src/hstc_pkg.sv
src/hstc_front.sv
src/hstc_queue.sv
src/hstc_back.sv
src/help_text_space_compressor_top.sv
tb/sv/tb_help_text_space_compressor_top.sv
